FILE: hdl/wheel_presieve_mask_gen_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wheel presieve mask generator
// Shared helpers that wrap a clocked implication with reset masking.
// ----------------------------------------------------------------------------
`ifndef WHEEL_PRESIEVE_MASK_GEN_MACROS_SVH
`define WHEEL_PRESIEVE_MASK_GEN_MACROS_SVH

// same-cycle implication, checked on i_clk, masked while i_rst_n is low
`define WPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on i_clk, masked while i_rst_n is low
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Types, constants and small residue helpers for the presieve mask generator.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

    // word geometry
    localparam int WORD_BITS    = 64;
    localparam int MAX_WORDS    = 64;
    localparam int DEF_MAX_BITS = 4096;
    localparam int COUNT_W      = 13;
    localparam int INDEX_W      = 6;

    // start value is reduced this many bits per cycle, MSB first
    localparam int DIGIT_BITS   = 4;
    localparam int START_W      = 64;
    localparam int DIGITS       = START_W / DIGIT_BITS;
    localparam int DIGIT_CNT_W  = $clog2(DIGITS);

    // queue between front and back
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    // wheel selector codes (unused code acts as the 30 wheel)
    localparam logic [1:0] SEL_30   = 2'd0;
    localparam logic [1:0] SEL_210  = 2'd1;
    localparam logic [1:0] SEL_1155 = 2'd2;

    // residue advance per word: 2 * WORD_BITS mod p
    localparam logic [3:0] ADV3  = 4'((2 * WORD_BITS) % 3);
    localparam logic [3:0] ADV5  = 4'((2 * WORD_BITS) % 5);
    localparam logic [3:0] ADV7  = 4'((2 * WORD_BITS) % 7);
    localparam logic [3:0] ADV11 = 4'((2 * WORD_BITS) % 11);

    // one classified item handed from front to back
    typedef struct packed {
        logic               parity;
        logic [1:0]         sel;
        logic [1:0]         r3;
        logic [2:0]         r5;
        logic [2:0]         r7;
        logic [3:0]         r11;
        logic [COUNT_W-1:0] count;
    } t_job;

    // (2r + b) mod p for r < p <= 11
    function automatic logic [3:0] dbl_mod(input logic [3:0] r, input logic b,
                                           input logic [3:0] p);
        logic [4:0] t;
        t = {r, b};
        if (t >= {1'b0, p}) begin
            t = t - {1'b0, p};
        end
        return t[3:0];
    endfunction

    // (a + c) mod p for a, c < p <= 11
    function automatic logic [3:0] add_mod(input logic [3:0] a, input logic [3:0] c,
                                           input logic [3:0] p);
        logic [4:0] s;
        s = {1'b0, a} + {1'b0, c};
        if (s >= {1'b0, p}) begin
            s = s - {1'b0, p};
        end
        return s[3:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/wheel_presieve_mask_gen.sv
// ----------------------------------------------------------------------------
// wheel_presieve_mask_gen
// Presieve mask words for the progression start, start+2, ... against the
// wheel modulus 30, 210 or 1155.
//
//   channel   dir   handshake            payload
//   input     in    i_valid / o_stall    i_start_value, i_bit_count
//   output    out   o_valid / i_stall    o_mask_word, o_word_index, o_last_word
//   config    in    i_cfg_we             i_cfg_data (wheel select)
//
// Front reduces the start value 4 bits a cycle, then hands the job on
// from its push state; it takes the next item while the back works.
// Back emits one word per cycle while not stalled, ceil(count/64) words,
// and pops the next job only once the last word of a job is loaded.
// Synchronous active-low reset; no clearing pass. An output stall holds
// the word register and backs up through a two-entry job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module wheel_presieve_mask_gen #(
    parameter int MAX_BITS = wpm_pkg::DEF_MAX_BITS
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_cfg_we,
    input  wire  [1:0]                     i_cfg_data,
    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire  [wpm_pkg::START_W-1:0]    i_start_value,
    input  wire  [wpm_pkg::COUNT_W-1:0]    i_bit_count,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [wpm_pkg::WORD_BITS-1:0]  o_mask_word,
    output logic [wpm_pkg::INDEX_W-1:0]    o_word_index,
    output logic                           o_last_word
);

    logic          w_push;
    logic          w_full;
    logic          w_pop;
    logic          w_nonempty;
    wpm_pkg::t_job w_front_job;
    wpm_pkg::t_job w_back_job;

    // classify and reduce
    wpm_front #(
        .MAX_BITS (MAX_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_value (i_start_value),
        .i_bit_count   (i_bit_count),
        .o_push        (w_push),
        .o_job         (w_front_job),
        .i_full        (w_full)
    );

    // job queue
    wpm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_front_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_job      (w_back_job)
    );

    // word generation
    wpm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (w_nonempty),
        .i_job        (w_back_job),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_mask_word  (o_mask_word),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word)
    );

endmodule

`default_nettype wire

FILE: hdl/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front
// Accepts items, clamps the count and reduces the start value to its
// residues mod 3, 5, 7 and 11, four bits per cycle, then hands a job on.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_front #(
    parameter int MAX_BITS = wpm_pkg::DEF_MAX_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [1:0]                   i_cfg_data,
    input  wire                          i_valid,
    output logic                         o_stall,
    input  wire  [wpm_pkg::START_W-1:0]  i_start_value,
    input  wire  [wpm_pkg::COUNT_W-1:0]  i_bit_count,
    output logic                         o_push,
    output wpm_pkg::t_job                o_job,
    input  wire                          i_full
);

    localparam int HARD_BOUND = wpm_pkg::MAX_WORDS * wpm_pkg::WORD_BITS;
    localparam int BOUND      = (MAX_BITS < HARD_BOUND) ? MAX_BITS : HARD_BOUND;
    localparam logic [wpm_pkg::COUNT_W-1:0] BOUND_C = wpm_pkg::COUNT_W'(BOUND);
    localparam logic [wpm_pkg::DIGIT_CNT_W-1:0] LAST_DIGIT =
        wpm_pkg::DIGIT_CNT_W'(wpm_pkg::DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PUSH
    } t_state;

    t_state                          r_state;
    logic [1:0]                      r_wheel_select;
    logic [wpm_pkg::START_W-1:0]     r_shift;
    logic [wpm_pkg::DIGIT_CNT_W-1:0] r_digit;
    wpm_pkg::t_job                   r_job;

    logic                            w_accept;
    logic [wpm_pkg::COUNT_W-1:0]     w_count;
    logic [3:0]                      n_r3, n_r5, n_r7, n_r11;

    assign w_accept = i_valid && (r_state == ST_IDLE);
    assign w_count  = (i_bit_count > BOUND_C) ? BOUND_C : i_bit_count;

    // four chained doubling steps per cycle on the top digit
    always_comb begin
        n_r3  = {2'b00, r_job.r3};
        n_r5  = {1'b0, r_job.r5};
        n_r7  = {1'b0, r_job.r7};
        n_r11 = r_job.r11;
        for (int k = 0; k < wpm_pkg::DIGIT_BITS; k++) begin
            n_r3  = wpm_pkg::dbl_mod(n_r3,  r_shift[wpm_pkg::START_W-1-k], 4'd3);
            n_r5  = wpm_pkg::dbl_mod(n_r5,  r_shift[wpm_pkg::START_W-1-k], 4'd5);
            n_r7  = wpm_pkg::dbl_mod(n_r7,  r_shift[wpm_pkg::START_W-1-k], 4'd7);
            n_r11 = wpm_pkg::dbl_mod(n_r11, r_shift[wpm_pkg::START_W-1-k], 4'd11);
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_wheel_select <= wpm_pkg::SEL_30;
            r_digit        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_wheel_select <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (w_count != '0)) begin
                        r_state      <= ST_RUN;
                        r_digit      <= '0;
                        r_shift      <= i_start_value;
                        r_job.parity <= i_start_value[0];
                        r_job.sel    <= r_wheel_select;
                        r_job.count  <= w_count;
                        r_job.r3     <= '0;
                        r_job.r5     <= '0;
                        r_job.r7     <= '0;
                        r_job.r11    <= '0;
                    end
                end
                ST_RUN: begin
                    r_job.r3  <= n_r3[1:0];
                    r_job.r5  <= n_r5[2:0];
                    r_job.r7  <= n_r7[2:0];
                    r_job.r11 <= n_r11;
                    r_shift   <= r_shift << wpm_pkg::DIGIT_BITS;
                    r_digit   <= r_digit + 1'b1;
                    if (r_digit == LAST_DIGIT) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    if (!i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_push  = (r_state == ST_PUSH) && !i_full;
    assign o_job   = r_job;

endmodule

`default_nettype wire

FILE: hdl/wpm_queue.sv
// ----------------------------------------------------------------------------
// wpm_queue
// Short job queue in flip-flops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wpm_pkg::t_job        i_job,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_nonempty,
    output wpm_pkg::t_job        o_job
);

    localparam logic [wpm_pkg::QCNT_W-1:0] DEPTH_C = wpm_pkg::QCNT_W'(wpm_pkg::QDEPTH);

    wpm_pkg::t_job                 r_mem [wpm_pkg::QDEPTH];
    logic [wpm_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [wpm_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [wpm_pkg::QCNT_W-1:0]    r_cnt;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_full     = (r_cnt == DEPTH_C);
    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

FILE: hdl/wpm_back.sv
// ----------------------------------------------------------------------------
// wpm_back
// Expands one job into mask words, one word per cycle, into an output
// register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wheel_presieve_mask_gen_macros.svh"

module wpm_back (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_nonempty,
    input  wpm_pkg::t_job                  i_job,
    output logic                           o_pop,
    output logic                           o_valid,
    input  wire                            i_stall,
    output logic [wpm_pkg::WORD_BITS-1:0]  o_mask_word,
    output logic [wpm_pkg::INDEX_W-1:0]    o_word_index,
    output logic                           o_last_word
);

    localparam logic [wpm_pkg::COUNT_W-1:0] WORD_C = wpm_pkg::COUNT_W'(wpm_pkg::WORD_BITS);

    logic                           r_busy;
    logic                           r_parity;
    logic [1:0]                     r_sel;
    logic [1:0]                     r_r3;
    logic [2:0]                     r_r5;
    logic [2:0]                     r_r7;
    logic [3:0]                     r_r11;
    logic [wpm_pkg::COUNT_W-1:0]    r_rem;
    logic [wpm_pkg::INDEX_W-1:0]    r_word;
    logic                           r_valid;
    logic [wpm_pkg::WORD_BITS-1:0]  r_mask;
    logic [wpm_pkg::INDEX_W-1:0]    r_index;
    logic                           r_last;

    logic                           w_load;
    logic                           w_last;
    logic                           w_use2, w_use7, w_use11;
    logic [wpm_pkg::WORD_BITS-1:0]  w_mask;
    logic [3:0]                     w_adv3, w_adv5, w_adv7, w_adv11;

    assign o_pop  = !r_busy && i_nonempty;
    assign w_load = r_busy && (!r_valid || !i_stall);
    assign w_last = (r_rem <= WORD_C);

    // which small primes divide the selected modulus
    assign w_use2  = (r_sel != wpm_pkg::SEL_1155);
    assign w_use7  = (r_sel == wpm_pkg::SEL_210) || (r_sel == wpm_pkg::SEL_1155);
    assign w_use11 = (r_sel == wpm_pkg::SEL_1155);

    // one lane per bit: residues of start + 2b, then the coprimality test
    for (genvar b = 0; b < wpm_pkg::WORD_BITS; b++) begin : g_lane
        localparam logic [3:0] C3  = 4'((2 * b) % 3);
        localparam logic [3:0] C5  = 4'((2 * b) % 5);
        localparam logic [3:0] C7  = 4'((2 * b) % 7);
        localparam logic [3:0] C11 = 4'((2 * b) % 11);
        logic [3:0] m3, m5, m7, m11;
        assign m3  = wpm_pkg::add_mod({2'b00, r_r3}, C3, 4'd3);
        assign m5  = wpm_pkg::add_mod({1'b0, r_r5}, C5, 4'd5);
        assign m7  = wpm_pkg::add_mod({1'b0, r_r7}, C7, 4'd7);
        assign m11 = wpm_pkg::add_mod(r_r11, C11, 4'd11);
        assign w_mask[b] = (r_rem > wpm_pkg::COUNT_W'(b)) &&
                           ((w_use2 && !r_parity) || (m3 == '0) || (m5 == '0) ||
                            (w_use7 && (m7 == '0)) || (w_use11 && (m11 == '0)));
    end

    // residues after one full word
    assign w_adv3  = wpm_pkg::add_mod({2'b00, r_r3}, wpm_pkg::ADV3, 4'd3);
    assign w_adv5  = wpm_pkg::add_mod({1'b0, r_r5}, wpm_pkg::ADV5, 4'd5);
    assign w_adv7  = wpm_pkg::add_mod({1'b0, r_r7}, wpm_pkg::ADV7, 4'd7);
    assign w_adv11 = wpm_pkg::add_mod(r_r11, wpm_pkg::ADV11, 4'd11);

    // job registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_rem   <= '0;
            r_word  <= '0;
        end else begin
            if (o_pop) begin
                r_busy   <= 1'b1;
                r_parity <= i_job.parity;
                r_sel    <= i_job.sel;
                r_r3     <= i_job.r3;
                r_r5     <= i_job.r5;
                r_r7     <= i_job.r7;
                r_r11    <= i_job.r11;
                r_rem    <= i_job.count;
                r_word   <= '0;
            end else if (w_load) begin
                r_r3   <= w_adv3[1:0];
                r_r5   <= w_adv5[2:0];
                r_r7   <= w_adv7[2:0];
                r_r11  <= w_adv11;
                r_word <= r_word + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_rem  <= '0;
                end else begin
                    r_rem <= r_rem - WORD_C;
                end
            end
            if (w_load) begin
                r_valid <= 1'b1;
                r_mask  <= w_mask;
                r_index <= r_word;
                r_last  <= w_last;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_mask_word  = r_mask;
    assign o_word_index = r_index;
    assign o_last_word  = r_last;

    // checks
    `WPM_ASSERT_NOW(a_busy_has_bits, r_busy, r_rem != '0, "busy with no bits left")
    `WPM_ASSERT_NEXT(a_last_ends_job, w_load && w_last, !r_busy, "job still busy after last word")
    `WPM_ASSERT_NEXT(a_index_steps, w_load && !w_last, r_word == $past(r_word) + 1'b1, "word index did not step")

endmodule

`default_nettype wire

FILE: bench/wheel_presieve_mask_gen_tb.sv
// ----------------------------------------------------------------------------
// wheel_presieve_mask_gen_tb
// Self-checking bench for the presieve mask generator. Sieve requests are
// fed through a valid/stall driver. Each accepted request is expanded into
// the mask words it must produce, and these are compared in order against
// the output beats. The wheel select is changed only while the block is
// idle, and the run steps through every selector value, the unused code
// among them. Both sides idle and stall in random bursts in phases that
// enable idling; the last phase never does.
// ----------------------------------------------------------------------------

module wheel_presieve_mask_gen_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WHEEL_30    = 30;
    localparam int          WHEEL_210   = 210;
    localparam int          WHEEL_1155  = 1155;
    localparam logic [1:0]  SEL_UNUSED  = 2'd3;
    localparam int          BIT_BOUND   = wpm_pkg::DEF_MAX_BITS;
    localparam int          SETTLE_CYC  = 40;
    localparam int          RAND_PER_PH = 37;

    typedef struct packed {
        logic [wpm_pkg::START_W-1:0] start;
        logic [wpm_pkg::COUNT_W-1:0] count;
    } t_sieve_req;

    typedef struct packed {
        logic [wpm_pkg::WORD_BITS-1:0] mask;
        logic [wpm_pkg::INDEX_W-1:0]   index;
        logic                          last;
    } t_mask_beat;

    // DUT ports
    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            i_cfg_we      = 1'b0;
    logic [1:0]                      i_cfg_data    = '0;
    logic                            i_valid       = 1'b0;
    logic                            o_stall;
    logic [wpm_pkg::START_W-1:0]     i_start_value = '0;
    logic [wpm_pkg::COUNT_W-1:0]     i_bit_count   = '0;
    logic                            o_valid;
    logic                            i_stall       = 1'b0;
    logic [wpm_pkg::WORD_BITS-1:0]   o_mask_word;
    logic [wpm_pkg::INDEX_W-1:0]     o_word_index;
    logic                            o_last_word;

    // stimulus and expectation stores
    t_sieve_req  pending_reqs[$];
    t_mask_beat  mask_expect_q[$];

    // own copy of the block state
    logic [1:0]  wheel_sel_copy = wpm_pkg::SEL_30;
    logic [10:0] residue_copy   = '0;
    logic [5:0]  word_cnt_copy  = '0;
    logic [12:0] bits_left_copy = '0;

    // bookkeeping
    int  err_count      = 0;
    int  reqs_queued    = 0;
    int  reqs_accepted  = 0;
    int  words_checked  = 0;
    int  zero_reqs      = 0;
    int  clamped_reqs   = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  req_beat_taken = 1'b0;
    bit  idle_on        = 1'b1;

    wheel_presieve_mask_gen u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_start_value (i_start_value),
        .i_bit_count   (i_bit_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_mask_word   (o_mask_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned wheel_modulus(input logic [1:0] sel);
        case (sel)
            wpm_pkg::SEL_210:  return WHEEL_210;
            wpm_pkg::SEL_1155: return WHEEL_1155;
            default:           return WHEEL_30;
        endcase
    endfunction

    // set when the residue shares a prime with the wheel
    function automatic bit hits_wheel(input int unsigned r, input int unsigned m);
        return ((m % 2 == 0) && (r % 2 == 0)) || (r % 3 == 0) || (r % 5 == 0) ||
               ((m % 7 == 0) && (r % 7 == 0)) || ((m % 11 == 0) && (r % 11 == 0));
    endfunction

    // expand one request into the mask words it must produce
    task automatic predict_mask_words(input logic [wpm_pkg::START_W-1:0] start,
                                      input logic [wpm_pkg::COUNT_W-1:0] count_in);
        int unsigned count;
        int unsigned m;
        int unsigned rem;
        int unsigned bits_left;
        int unsigned nwords;
        t_mask_beat  beat;
        count = count_in;
        if (count > BIT_BOUND) begin
            count = BIT_BOUND;
            clamped_reqs++;
        end
        if (count > wpm_pkg::MAX_WORDS * wpm_pkg::WORD_BITS) begin
            count = wpm_pkg::MAX_WORDS * wpm_pkg::WORD_BITS;
        end
        if (count == 0) begin
            zero_reqs++;
            return;
        end
        m         = wheel_modulus(wheel_sel_copy);
        rem       = int'(start % 64'(m));
        bits_left = count;
        nwords    = (count + wpm_pkg::WORD_BITS - 1) / wpm_pkg::WORD_BITS;
        for (int unsigned w = 0; w < nwords; w++) begin
            beat = '0;
            for (int b = 0; b < wpm_pkg::WORD_BITS && bits_left != 0; b++) begin
                if (hits_wheel(rem, m)) beat.mask[b] = 1'b1;
                rem = rem + 2;
                if (rem >= m) rem = rem - m;
                bits_left--;
            end
            beat.index = wpm_pkg::INDEX_W'(w);
            beat.last  = (w + 1 == nwords);
            mask_expect_q.insert(mask_expect_q.size(), beat);
        end
        residue_copy   = 11'(rem);
        word_cnt_copy  = 6'(nwords);
        bits_left_copy = '0;
    endtask

    // request side: note accepted beats and predict their words
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_mask_words(i_start_value, i_bit_count);
            reqs_accepted++;
            req_beat_taken = 1'b1;
        end
    end

    // request driver
    always @(negedge i_clk) begin : req_drive
        logic                        v;
        logic [wpm_pkg::START_W-1:0] s;
        logic [wpm_pkg::COUNT_W-1:0] c;
        t_sieve_req                  req;
        v = i_valid;
        s = i_start_value;
        c = i_bit_count;
        if (req_beat_taken) v = 1'b0;
        req_beat_taken = 1'b0;
        if (!v && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 18);
                end else begin
                    req = pending_reqs.pop_front();
                    v   = 1'b1;
                    s   = req.start;
                    c   = req.count;
                end
            end
        end
        i_valid       <= v;
        i_start_value <= s;
        i_bit_count   <= c;
    end

    // result stall bursts
    always @(negedge i_clk) begin : stall_drive
        logic st;
        st = 1'b0;
        if (stall_left > 0) begin
            st = 1'b1;
            stall_left--;
        end else if (idle_on && i_rst_n && $urandom_range(0, 9) == 0) begin
            st = 1'b1;
            stall_left = $urandom_range(0, 18);
        end
        i_stall <= st;
    end

    // result checker
    always @(posedge i_clk) begin : word_check
        t_mask_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (mask_expect_q.size() == 0) begin
                $display("%0t: unexpected word mask=%h index=%0d last=%0b",
                         $time, o_mask_word, o_word_index, o_last_word);
                err_count++;
            end else begin
                want = mask_expect_q.pop_front();
                words_checked++;
                if (o_mask_word !== want.mask) begin
                    $display("%0t: mask_word expected %h actual %h",
                             $time, want.mask, o_mask_word);
                    err_count++;
                end
                if (o_word_index !== want.index) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.index, o_word_index);
                    err_count++;
                end
                if (o_last_word !== want.last) begin
                    $display("%0t: last_word expected %0b actual %0b",
                             $time, want.last, o_last_word);
                    err_count++;
                end
            end
        end
    end

    task automatic queue_req(input logic [wpm_pkg::START_W-1:0] start,
                             input logic [wpm_pkg::COUNT_W-1:0] count);
        t_sieve_req req;
        req.start = start;
        req.count = count;
        pending_reqs.insert(pending_reqs.size(), req);
        reqs_queued++;
    endtask

    function automatic logic [wpm_pkg::START_W-1:0] rand_start();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 5000));
            1:       return ~64'($urandom_range(0, 5000));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly short counts, some long, some over the bound, a few zero
    function automatic logic [wpm_pkg::COUNT_W-1:0] rand_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 50) return 13'($urandom_range(1, 128));
        if (r < 72) return 13'($urandom_range(129, 4096));
        if (r < 85) return 13'($urandom_range(4097, 8191));
        return 13'(wpm_pkg::WORD_BITS * $urandom_range(1, 64) + $urandom_range(0, 2) - 1);
    endfunction

    // wait until every queued beat is taken and every word has arrived
    task automatic drain();
        while (reqs_accepted != reqs_queued || mask_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_wheel(input logic [1:0] sel);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= sel;
        @(posedge i_clk);
        wheel_sel_copy = sel;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // run limit
    initial begin
        #20ms;
        $display("%0t: timeout, %0d words still expected", $time, mask_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]  wheel_plan[6];
        int unsigned m;
        wheel_plan = '{wpm_pkg::SEL_1155, wpm_pkg::SEL_210, SEL_UNUSED,
                       wpm_pkg::SEL_30, wpm_pkg::SEL_210, wpm_pkg::SEL_1155};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset wheel, word edges, clamp, zero counts
        queue_req(64'd0, 13'd1);
        queue_req(64'd1, 13'd1);
        queue_req('1, 13'd1);
        queue_req('1, 13'd8191);
        queue_req(64'd0, 13'd4096);
        queue_req(64'h8000_0000_0000_0000, 13'd4097);
        queue_req(64'd29, 13'd63);
        queue_req(64'd30, 13'd64);
        queue_req(64'd31, 13'd65);
        queue_req(64'd12345, 13'd0);
        queue_req(64'd7, 13'd128);
        queue_req(64'hFFFF_FFFF_FFFF_FFFE, 13'd4095);
        queue_req(64'd1, 13'd0);
        drain();

        // one phase per wheel setting; the last runs without idling
        foreach (wheel_plan[p]) begin
            write_wheel(wheel_plan[p]);
            idle_on = (p == 5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            m = wheel_modulus(wheel_plan[p]);
            queue_req(64'd0, 13'd1);
            queue_req(64'(m - 1), 13'd64);
            for (int k = 0; k < RAND_PER_PH; k++) queue_req(rand_start(), rand_count());
            drain();
        end

        $display("covered %0d requests (%0d zero, %0d clamped) over all wheel selects",
                 reqs_accepted, zero_reqs, clamped_reqs);
        $display("checked %0d mask words", words_checked);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
